FILE: sv/hecc_pkg.sv
// Shared types, constants and Hamming(7,4) coding functions for the ECC byte memory.
// No dependencies; imported by the top level of the block.
package hecc_pkg;

  // Field and register widths.
  localparam int unsigned SIZE_W   = 11;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned ADDR_W   = 10;
  localparam int unsigned FBIT_W   = 13;
  localparam int unsigned CELL_W   = 8;
  localparam int unsigned CFG_W    = 16;
  // Scrub index width: covers twice the largest active size.
  localparam int unsigned SCAN_W   = SIZE_W + 1;

  // Register reset values.
  localparam logic [SIZE_W-1:0]   ACTIVE_SIZE_RST  = 11'd128;
  localparam logic [PERIOD_W-1:0] SCRUB_PERIOD_RST = 16'd2000;

  // Configuration register indexes.
  localparam logic CFG_ACTIVE_SIZE  = 1'b0;
  localparam logic CFG_SCRUB_PERIOD = 1'b1;

  // Input actions, carried in tuser.
  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_FAULT = 2'd2,
    ACT_TICK  = 2'd3
  } action_e;

  // Bit to flip for each syndrome value.
  function automatic logic [CELL_W-1:0] syn_fix(input logic [2:0] s);
    logic [CELL_W-1:0] f;
    unique case (s)
      3'd0: f = 8'h00;
      3'd1: f = 8'h10;
      3'd2: f = 8'h20;
      3'd3: f = 8'h08;
      3'd4: f = 8'h40;
      3'd5: f = 8'h04;
      3'd6: f = 8'h02;
      default: f = 8'h01;
    endcase
    return f;
  endfunction

  // Encode one nibble into a 7-bit codeword held in an 8-bit cell.
  function automatic logic [CELL_W-1:0] enc_nib(input logic [3:0] d);
    return {1'b0, ^(d & 4'h7), ^(d & 4'hB), ^(d & 4'hD), d};
  endfunction

  // Decode one cell with single-bit correction; bit seven is ignored.
  function automatic logic [3:0] dec_nib(input logic [CELL_W-1:0] c);
    logic [2:0]        s;
    logic [CELL_W-1:0] fixed;
    s     = {^(c & 8'h47), ^(c & 8'h2B), ^(c & 8'h1D)};
    fixed = c ^ syn_fix(s);
    return fixed[3:0];
  endfunction

endpackage

FILE: sv/hecc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; instanced by the ECC byte memory for its codeword store.
module hecc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/hamming_ecc_byte_memory_with_scrub.sv
// Top level of the Hamming(7,4) protected byte memory with periodic scrubbing.
// Depends on hecc_pkg and hecc_ram.
//
// Usage:
//   Input items arrive on the s_axis channel; tuser carries the action (write,
//   read, fault injection, time tick) and tdata the address, data and fault bit.
//   Every accepted item gives exactly one result on m_axis: tdata is the read
//   byte (zero unless a read succeeded), tuser is the reject flag.
//   Items are handled one at a time. After the accepting edge a write steps
//   through WR_HI and WR_LO, a read through RD_HI and RD_LO, a fault through FLT,
//   a rejected item or a tick goes straight to FINISH, and a tick that starts a
//   scrub pass walks 2*size cells of the codeword RAM in SCRUB, one cell a cycle
//   through its single read and single write port. FINISH loads the result
//   register, and the next item can be taken in the cycle after the load.
//   The output register parts the two sides: a new item is taken while an
//   earlier result waits. When the receiver stalls and a new result is ready,
//   the block holds in its final step until the output register frees up.
//   After reset all 2*DEPTH cells of the codeword RAM are cleared, one cell a cycle;
//   s_axis_tready stays low meanwhile, configuration writes are taken.
//   Configuration is written through cfg_we_i, cfg_index_i and cfg_wdata_i, by
//   the user only while the block is idle; the block itself does not enforce it.
module hamming_ecc_byte_memory_with_scrub
  import hecc_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // byte_address[9:0], write_data[17:10], fault_bit[30:18]
  input  logic [1:0]  s_axis_tuser,  // action[1:0]
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // rd_byte[7:0]
  output logic        m_axis_tuser   // status[0]
);

  localparam int unsigned CELLS  = 2 * DEPTH;
  localparam int unsigned CW     = $clog2(CELLS);
  localparam logic [CW-1:0] LAST_CELL = CW'(CELLS - 1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_HI,
    ST_WR_LO,
    ST_RD_HI,
    ST_RD_LO,
    ST_FLT,
    ST_SCRUB,
    ST_FINISH
  } state_e;

  state_e              state_q;
  logic [SIZE_W-1:0]   active_size_q;
  logic [PERIOD_W-1:0] scrub_period_q;
  logic [PERIOD_W-1:0] tick_q;
  logic [CW-1:0]       clr_q;
  logic [SCAN_W-1:0]   scan_q;
  logic [CW-1:0]       cell_q;
  logic [7:0]          wd_q;
  logic [2:0]          bit_q;
  logic [3:0]          hi_q;
  logic [7:0]          res_data_q;
  logic                res_status_q;
  logic                m_tvalid_q;
  logic [7:0]          m_tdata_q;
  logic                m_tuser_q;

  // RAM port signals.
  logic              ram_we;
  logic [CW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [CW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  // Input field decode.
  action_e           in_act;
  logic [ADDR_W-1:0] in_addr;
  logic [7:0]        in_wdata;
  logic [FBIT_W-1:0] in_fbit;
  logic [SIZE_W-1:0] size;
  logic [SCAN_W-1:0] limit;
  logic [CW-1:0]     in_cell;
  logic [CW-1:0]     in_fcell;
  logic              addr_bad;
  logic              fbit_bad;
  logic [PERIOD_W-1:0] period;
  logic [PERIOD_W-1:0] tick_next;
  logic              scrub_due;
  logic              scrub_go;
  logic [CW-1:0]     cell_lo;
  logic [3:0]        dec_now;
  logic              out_free;

  assign in_act   = action_e'(s_axis_tuser);
  assign in_addr  = s_axis_tdata[9:0];
  assign in_wdata = s_axis_tdata[17:10];
  assign in_fbit  = s_axis_tdata[30:18];

  // Bytes in use, capped at the store depth.
  assign size  = (32'(active_size_q) > DEPTH) ? SIZE_W'(DEPTH) : active_size_q;
  assign limit = {size, 1'b0};

  assign in_cell  = CW'({in_addr, 1'b0});
  assign in_fcell = CW'(in_fbit[FBIT_W-1:3]);
  assign addr_bad = {1'b0, in_addr} >= size;
  assign fbit_bad = {1'b0, in_fbit} >= {size, 3'b000};

  // Tick counting against the period, a zero period counting as one.
  assign period    = (scrub_period_q == '0) ? PERIOD_W'(1) : scrub_period_q;
  assign tick_next = tick_q + PERIOD_W'(1);
  assign scrub_due = tick_next >= period;
  assign scrub_go  = scrub_due && (size != '0);

  assign cell_lo  = {cell_q[CW-1:1], 1'b1};
  assign dec_now  = dec_nib(ram_rdata);
  assign out_free = !m_tvalid_q || m_axis_tready;

  // RAM access for each step.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cell_q;
    ram_wdata = enc_nib(dec_now);
    ram_re    = 1'b0;
    ram_raddr = cell_lo;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        unique case (in_act)
          ACT_READ: begin
            ram_re    = s_axis_tvalid && !addr_bad;
            ram_raddr = in_cell;
          end
          ACT_FAULT: begin
            ram_re    = s_axis_tvalid && !fbit_bad;
            ram_raddr = in_fcell;
          end
          ACT_TICK: begin
            ram_re    = s_axis_tvalid && scrub_go;
            ram_raddr = '0;
          end
          default: begin
            ram_re = 1'b0;
          end
        endcase
      end
      ST_WR_HI: begin
        ram_we    = 1'b1;
        ram_wdata = enc_nib(wd_q[7:4]);
      end
      ST_WR_LO: begin
        ram_we    = 1'b1;
        ram_waddr = cell_lo;
        ram_wdata = enc_nib(wd_q[3:0]);
      end
      ST_RD_HI: begin
        ram_we = 1'b1;
        ram_re = 1'b1;
      end
      ST_RD_LO: begin
        ram_we    = 1'b1;
        ram_waddr = cell_lo;
      end
      ST_FLT: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata ^ (CELL_W'(1) << bit_q);
      end
      ST_SCRUB: begin
        ram_we    = 1'b1;
        ram_waddr = CW'(scan_q - SCAN_W'(1));
        ram_re    = scan_q != limit;
        ram_raddr = CW'(scan_q);
      end
      ST_FINISH: begin
        ram_we = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Control sequence, configuration registers and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      active_size_q  <= ACTIVE_SIZE_RST;
      scrub_period_q <= SCRUB_PERIOD_RST;
      tick_q         <= '0;
      clr_q          <= '0;
      scan_q         <= '0;
      cell_q         <= '0;
      wd_q           <= '0;
      bit_q          <= '0;
      hi_q           <= '0;
      res_data_q     <= '0;
      res_status_q   <= 1'b0;
      m_tvalid_q     <= 1'b0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + CW'(1);
          if (clr_q == LAST_CELL) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            cell_q     <= (in_act == ACT_FAULT) ? in_fcell : in_cell;
            wd_q       <= in_wdata;
            bit_q      <= in_fbit[2:0];
            res_data_q <= '0;
            unique case (in_act)
              ACT_WRITE: begin
                res_status_q <= addr_bad;
                state_q      <= addr_bad ? ST_FINISH : ST_WR_HI;
              end
              ACT_READ: begin
                res_status_q <= addr_bad;
                state_q      <= addr_bad ? ST_FINISH : ST_RD_HI;
              end
              ACT_FAULT: begin
                res_status_q <= fbit_bad;
                state_q      <= fbit_bad ? ST_FINISH : ST_FLT;
              end
              ACT_TICK: begin
                res_status_q <= 1'b0;
                scan_q       <= SCAN_W'(1);
                state_q      <= scrub_go ? ST_SCRUB : ST_FINISH;
              end
              default: begin
                res_status_q <= 1'b0;
                state_q      <= ST_FINISH;
              end
            endcase
          end
        end
        ST_WR_HI: begin
          state_q <= ST_WR_LO;
        end
        ST_WR_LO: begin
          state_q <= ST_FINISH;
        end
        ST_RD_HI: begin
          hi_q    <= dec_now;
          state_q <= ST_RD_LO;
        end
        ST_RD_LO: begin
          res_data_q <= {hi_q, dec_now};
          state_q    <= ST_FINISH;
        end
        ST_FLT: begin
          state_q <= ST_FINISH;
        end
        ST_SCRUB: begin
          scan_q <= scan_q + SCAN_W'(1);
          if (scan_q == limit) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      // Result valid: set when a result is loaded, cleared by its transfer.
      if (state_q == ST_FINISH && out_free) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
      // Tick count; a period write restarts it.
      if (cfg_we_i && cfg_index_i == CFG_SCRUB_PERIOD) begin
        tick_q <= '0;
      end else if (state_q == ST_IDLE && s_axis_tvalid && in_act == ACT_TICK) begin
        tick_q <= scrub_due ? '0 : tick_next;
      end
      // Configuration writes.
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_ACTIVE_SIZE) begin
          active_size_q <= cfg_wdata_i[SIZE_W-1:0];
        end else begin
          scrub_period_q <= cfg_wdata_i[PERIOD_W-1:0];
        end
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_FINISH && out_free) begin
      m_tdata_q <= res_data_q;
      m_tuser_q <= res_status_q;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

  // Codeword store.
  hecc_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

endmodule

FILE: sv/hecc_checker.sv
// Port-level checker for the ECC byte memory, with its bind to the top level.
// No dependencies beyond the top level's port list.
module hecc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tuser
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A rejected item never returns data.
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'd0)
    else $error("rejected item returned nonzero data");

  // Items are handled one at a time: no transfer in the cycle after one.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a transfer");

  // A new result only appears while the block is busy with an item.
  a_result_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while the block was idle");

endmodule

bind hamming_ecc_byte_memory_with_scrub hecc_checker u_hecc_checker (.*);

FILE: tb/hecc_reply_checker.sv
// Result checker for the Hamming(7,4) byte memory: watches the config port and both streams.
// Keeps its own copy of the codeword cells, predicts each reply and compares in order.
// Depends on hecc_pkg for the action codes, register indexes and reset values.
module hecc_reply_checker
  import hecc_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // byte_address[9:0], write_data[17:10], fault_bit[30:18]
  input  logic [1:0]  s_axis_tuser,  // action[1:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,  // rd_byte[7:0]
  input  logic        m_axis_tuser,  // status[0]
  output int          mismatches_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] rd_byte;
    logic       status;
  } reply_t;

  // Shadow memory state and registers.
  logic [7:0]  cells [2*DEPTH];
  logic [15:0] tick_q;
  logic [10:0] size_q;
  logic [15:0] period_q;
  reply_t      replies_due [$];

  // Hamming(7,4) encoder: parity bits 6..4 over data bit groups {0,1,2}, {0,1,3}, {0,2,3}.
  function automatic logic [7:0] hamming_encode(input logic [3:0] d);
    logic p6, p5, p4;
    p6 = d[0] ^ d[1] ^ d[2];
    p5 = d[0] ^ d[1] ^ d[3];
    p4 = d[0] ^ d[2] ^ d[3];
    return {1'b0, p6, p5, p4, d};
  endfunction

  // Decoder: the syndrome names the bad bit; only a hit on a data bit changes the nibble.
  // Bit seven takes part in no check.
  function automatic logic [3:0] hamming_decode(input logic [7:0] c);
    logic [2:0] syn;
    logic [3:0] d;
    syn = {c[6] ^ c[2] ^ c[1] ^ c[0],
           c[5] ^ c[3] ^ c[1] ^ c[0],
           c[4] ^ c[3] ^ c[2] ^ c[0]};
    d = c[3:0];
    case (syn)
      3'b011: d[3] = ~d[3];
      3'b101: d[2] = ~d[2];
      3'b110: d[1] = ~d[1];
      3'b111: d[0] = ~d[0];
      default: ;
    endcase
    return d;
  endfunction

  // Apply one memory operation to the shadow state and work out its reply.
  task automatic run_memory_op(input action_e op, input logic [9:0] addr,
                               input logic [7:0] wd, input logic [12:0] fb,
                               output reply_t r);
    int unsigned span;
    int unsigned lim;
    logic [3:0]  hi;
    logic [3:0]  lo;
    span = (size_q > DEPTH) ? DEPTH : size_q;
    r    = '0;
    case (op)
      ACT_WRITE: begin
        if (addr >= span) begin
          r.status = 1'b1;
        end else begin
          cells[{addr, 1'b0}] = hamming_encode(wd[7:4]);
          cells[{addr, 1'b1}] = hamming_encode(wd[3:0]);
        end
      end
      ACT_READ: begin
        if (addr >= span) begin
          r.status = 1'b1;
        end else begin
          hi = hamming_decode(cells[{addr, 1'b0}]);
          lo = hamming_decode(cells[{addr, 1'b1}]);
          r.rd_byte = {hi, lo};
          cells[{addr, 1'b0}] = hamming_encode(hi);
          cells[{addr, 1'b1}] = hamming_encode(lo);
        end
      end
      ACT_FAULT: begin
        if (fb >= 8 * span) begin
          r.status = 1'b1;
        end else begin
          cells[fb[12:3]][fb[2:0]] = ~cells[fb[12:3]][fb[2:0]];
        end
      end
      default: begin
        // Tick: a zero period behaves as one; on expiry every cell in use is rewritten.
        lim    = (period_q == 16'd0) ? 1 : period_q;
        tick_q = tick_q + 16'd1;
        if (tick_q >= lim) begin
          for (int unsigned i = 0; i < 2 * span; i++) begin
            cells[i] = hamming_encode(hamming_decode(cells[i]));
          end
          tick_q = '0;
        end
      end
    endcase
  endtask

  // Replies are checked before the new input is predicted; a reply never belongs
  // to an input taken at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    reply_t got;
    if (!rst_ni) begin
      for (int i = 0; i < 2 * DEPTH; i++) begin
        cells[i] = '0;
      end
      tick_q       = '0;
      size_q       = ACTIVE_SIZE_RST;
      period_q     = SCRUB_PERIOD_RST;
      mismatches_o = 0;
      replies_due.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_ACTIVE_SIZE) begin
          size_q = cfg_wdata_i[10:0];
        end else begin
          period_q = cfg_wdata_i;
          tick_q   = '0;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata, m_axis_tuser};
        if (replies_due.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10) begin
            $display("ERROR: unexpected reply rd_byte=%02h status=%0d at %0t",
                     got.rd_byte, got.status, $realtime);
          end
        end else begin
          want = replies_due.pop_front();
          if (got.rd_byte !== want.rd_byte || got.status !== want.status) begin
            mismatches_o++;
            if (mismatches_o <= 10) begin
              $display("ERROR: mismatch at %0t: byte exp %02h got %02h, status exp %0d got %0d",
                       $realtime, want.rd_byte, got.rd_byte, want.status, got.status);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        run_memory_op(action_e'(s_axis_tuser), s_axis_tdata[9:0], s_axis_tdata[17:10],
                      s_axis_tdata[30:18], want);
        replies_due.push_back(want);
      end
    end
    pending_o = replies_due.size();
  end

endmodule

FILE: tb/tb_hamming_ecc_byte_memory_with_scrub.sv
// Testbench top for hamming_ecc_byte_memory_with_scrub: clock, reset, stimulus and verdict.
// Directed accesses and faults first, then random phases over several size and period settings.
// Depends on hecc_pkg, the block itself and hecc_reply_checker.
module tb_hamming_ecc_byte_memory_with_scrub;
  import hecc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH      = 1024;
  localparam int          NUM_PHASES = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = CFG_ACTIVE_SIZE;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // byte_address[9:0], write_data[17:10], fault_bit[30:18]
  logic [1:0]  s_axis_tuser = ACT_WRITE;  // action[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;  // rd_byte[7:0]
  logic        m_axis_tuser;  // status[0]

  int          mismatches;
  int          pending;
  int unsigned span_now = 128;
  int          burst_left = 0;

  hamming_ecc_byte_memory_with_scrub #(.DEPTH(DEPTH)) u_top (.*);

  hecc_reply_checker #(.DEPTH(DEPTH)) u_reply_check (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .mismatches_o(mismatches), .pending_o(pending)
  );

  always #1ns clk_i = ~clk_i;

  // Receiver backpressure: each stall mode holds for a randomly drawn span, then a new one is picked.
  int stall_mode = 0;
  int stall_left = 0;
  int rx_cycle   = 0;
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 80);
    end
    stall_left--;
    rx_cycle++;
    case (stall_mode)
      0:       m_axis_tready = 1'b1;
      1:       m_axis_tready = $urandom_range(0, 1);
      2:       m_axis_tready = ($urandom_range(0, 3) == 0);
      default: m_axis_tready = (rx_cycle % 5 != 0);
    endcase
  end

  // One transfer on the input stream; bursts of random length with random gaps between them.
  task automatic send_item(input action_e op, input logic [9:0] addr,
                           input logic [7:0] wd, input logic [12:0] fb);
    @(negedge clk_i);
    if (burst_left == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {1'b0, fb, wd, addr};
    s_axis_tuser  = op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Hold the input stream idle until every reply has come back.
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    burst_left    = 0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic set_register(input logic idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // Size, scrub period and item count of each random phase.
  task automatic phase_plan(input int p, output logic [10:0] sz, output logic [15:0] per,
                            output int cnt);
    case (p)
      0:       begin sz = 11'd16;   per = 16'd5;     cnt = 300; end
      1:       begin sz = 11'd1024; per = 16'd30;    cnt = 250; end
      2:       begin sz = 11'd0;    per = 16'd0;     cnt = 50;  end
      3:       begin sz = 11'd2047; per = 16'd1;     cnt = 40;  end
      4:       begin sz = 11'd1;    per = 16'd2;     cnt = 150; end
      5:       begin sz = 11'd8;    per = 16'd0;     cnt = 150; end
      6:       begin sz = 11'd64;   per = 16'd3;     cnt = 300; end
      default: begin sz = 11'd300;  per = 16'd65535; cnt = 290; end
    endcase
  endtask

  // Mostly in-range addresses and fault bits, with some out-of-range noise.
  function automatic logic [9:0] pick_addr();
    if (span_now == 0 || $urandom_range(0, 9) == 0) return 10'($urandom_range(0, 1023));
    return 10'($urandom_range(0, span_now - 1));
  endfunction

  function automatic logic [12:0] pick_fault_bit();
    if (span_now == 0 || $urandom_range(0, 9) == 0) return 13'($urandom_range(0, 8191));
    return 13'($urandom_range(0, 8 * span_now - 1));
  endfunction

  initial begin : stimulus
    logic [10:0] sz;
    logic [15:0] per;
    int          cnt;
    int          pick;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset settings: extremes, rejects, single and double errors.
    send_item(ACT_WRITE, 10'd0,    8'h00, 13'd0);
    send_item(ACT_WRITE, 10'd127,  8'hFF, 13'd0);
    send_item(ACT_READ,  10'd0,    8'h00, 13'd0);
    send_item(ACT_READ,  10'd127,  8'h00, 13'd0);
    send_item(ACT_WRITE, 10'd128,  8'h5A, 13'd0);
    send_item(ACT_READ,  10'd1023, 8'h00, 13'd0);
    send_item(ACT_READ,  10'd5,    8'h00, 13'd0);
    send_item(ACT_FAULT, 10'd0,    8'h00, 13'd0);
    send_item(ACT_READ,  10'd0,    8'h00, 13'd0);
    // Top bit of a cell is outside the code and gets cleared by the next read.
    send_item(ACT_FAULT, 10'd0,    8'h00, 13'd7);
    send_item(ACT_READ,  10'd0,    8'h00, 13'd0);
    send_item(ACT_FAULT, 10'd0,    8'h00, 13'd1023);
    send_item(ACT_FAULT, 10'd0,    8'h00, 13'd1024);
    send_item(ACT_FAULT, 10'd0,    8'h00, 13'd8191);
    send_item(ACT_WRITE, 10'd3,    8'hA5, 13'd0);
    send_item(ACT_FAULT, 10'd0,    8'h00, 13'd52);
    send_item(ACT_FAULT, 10'd0,    8'h00, 13'd62);
    send_item(ACT_READ,  10'd3,    8'h00, 13'd0);
    // Two flips in one codeword: the decoder miscorrects.
    send_item(ACT_FAULT, 10'd0,    8'h00, 13'd50);
    send_item(ACT_FAULT, 10'd0,    8'h00, 13'd53);
    send_item(ACT_READ,  10'd3,    8'h00, 13'd0);
    send_item(ACT_TICK,  10'd0,    8'h00, 13'd0);
    send_item(ACT_TICK,  10'd1023, 8'hFF, 13'd8191);
    drain();

    // Random phases; registers change only while the block is idle.
    for (int p = 0; p < NUM_PHASES; p++) begin
      phase_plan(p, sz, per, cnt);
      set_register(CFG_ACTIVE_SIZE, {5'($urandom), sz});
      set_register(CFG_SCRUB_PERIOD, per);
      span_now = (sz > DEPTH) ? DEPTH : sz;
      for (int n = 0; n < cnt; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          send_item(ACT_WRITE, pick_addr(), 8'($urandom_range(0, 255)), 13'($urandom));
        end else if (pick < 60) begin
          send_item(ACT_READ, pick_addr(), 8'($urandom), 13'($urandom));
        end else if (pick < 80) begin
          send_item(ACT_FAULT, 10'($urandom), 8'($urandom), pick_fault_bit());
        end else begin
          send_item(ACT_TICK, 10'($urandom), 8'($urandom), 13'($urandom));
        end
        if ($urandom_range(0, 199) == 0) drain();
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #2_000_000ns;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
